FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the bounded insert/shift array.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BISA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define BISA_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define BISA_ASSERT(lbl, clk, rst, prop)
`define BISA_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: rtl/bisa_pkg.sv
// Package: types and constants for the bounded insert/shift array.
package bisa_pkg;

   localparam int DATA_W        = 32;
   localparam int POS_W         = 6;
   localparam int CAP_W         = 6;
   localparam int DEPTH_DEFAULT = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

   typedef enum logic [2:0] {
      MODE_INSERT    = 3'd0,
      MODE_POP_FRONT = 3'd1,
      MODE_POP_BACK  = 3'd2,
      MODE_READ      = 3'd3,
      MODE_WRITE     = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic ins;
      logic pop;
      logic wr;
   } cell_ctrl_type;

endpackage

FILE: rtl/bounded_insert_shift_array_unit.sv
// Top level: ordered store of signed words built as a chain of shift cells.
// The response is registered: response valid rises in the cycle after a request is accepted.
// Throughput: one request per cycle while req_stall is low; every cell shifts in parallel.
// Requests stall only while a response is held by a stalled consumer.
// Reset clears the entry count, response valid and sets the capacity to 20.
// Cell contents are not reset; entries at or above the count are never read.
`include "assert_macros.svh"

module bounded_insert_shift_array_unit #(
   parameter int DEPTH = bisa_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_mode,
   input  logic [bisa_pkg::POS_W-1:0]         req_position,
   input  logic signed [bisa_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bisa_pkg::DATA_W-1:0] rsp_read_value,
   output logic [1:0]                         rsp_status,
   output logic [bisa_pkg::POS_W-1:0]         rsp_entry_count,
   input  logic                               csr_write_enable,
   input  logic [bisa_pkg::CAP_W-1:0]         csr_write_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > bisa_pkg::POS_W) ? CNT_W : bisa_pkg::POS_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic [bisa_pkg::CAP_W-1:0]  csr_capacity_limit_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [bisa_pkg::DATA_W-1:0] rsp_read_value_ff;
   logic [bisa_pkg::DATA_W-1:0] rsp_read_value_in;
   bisa_pkg::status_type        rsp_status_ff;
   bisa_pkg::status_type        rsp_status_in;
   logic [bisa_pkg::POS_W-1:0]  rsp_entry_count_ff;

   logic                        accept;
   logic [CMP_W-1:0]            pos_ext;
   logic [CMP_W-1:0]            count_ext;
   logic [CMP_W-1:0]            count_in_ext;
   logic [CMP_W-1:0]            cap_ext;
   logic [CMP_W-1:0]            limit;
   logic [bisa_pkg::DATA_W-1:0] rd_sel;
   bisa_pkg::cell_ctrl_type     op;
   bisa_pkg::cell_ctrl_type     cell_ctrl;

   logic [DEPTH-1:0][bisa_pkg::DATA_W-1:0] cell_q;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_ext   = CMP_W'(req_position);
   assign count_ext = CMP_W'(count_ff);
   assign cap_ext   = CMP_W'(csr_capacity_limit_ff);
   assign limit     = (cap_ext < DEPTH_C) ? cap_ext : DEPTH_C;

   // entry select for reads
   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pos_ext == CMP_W'(i)) begin
            rd_sel = rd_sel | cell_q[i];
         end
      end
   end

   // request decode
   always_comb begin
      op                = '0;
      count_in          = count_ff;
      rsp_status_in     = bisa_pkg::ST_OK;
      rsp_read_value_in = '0;
      unique case (bisa_pkg::mode_type'(req_mode))
         bisa_pkg::MODE_INSERT: begin
            if (count_ext >= limit) begin
               rsp_status_in = bisa_pkg::ST_FULL;
            end else if (pos_ext > count_ext) begin
               rsp_status_in = bisa_pkg::ST_RANGE;
            end else begin
               op.ins   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         bisa_pkg::MODE_POP_FRONT: begin
            if (count_ff == '0) begin
               rsp_status_in = bisa_pkg::ST_EMPTY;
            end else begin
               op.pop   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         bisa_pkg::MODE_POP_BACK: begin
            if (count_ff == '0) begin
               rsp_status_in = bisa_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         bisa_pkg::MODE_READ: begin
            if (pos_ext >= count_ext) begin
               rsp_status_in = bisa_pkg::ST_RANGE;
            end else begin
               rsp_read_value_in = rd_sel;
            end
         end
         bisa_pkg::MODE_WRITE: begin
            if (pos_ext >= count_ext) begin
               rsp_status_in = bisa_pkg::ST_RANGE;
            end else begin
               op.wr = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign cell_ctrl    = accept ? op : '0;
   assign count_in_ext = CMP_W'(count_in);
   assign rsp_valid_in = accept || req_stall;

   generate
      for (genvar g = 0; g < DEPTH; g++) begin : g_cell
         logic [bisa_pkg::DATA_W-1:0] left_q;
         logic [bisa_pkg::DATA_W-1:0] right_q;
         if (g == 0) begin : g_first
            assign left_q = cell_q[g];
         end else begin : g_mid_l
            assign left_q = cell_q[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_q = cell_q[g];
         end else begin : g_mid_r
            assign right_q = cell_q[g+1];
         end
         bisa_cell #(
            .INDEX (g),
            .CMP_W (CMP_W)
         ) u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .position (pos_ext),
            .value    (req_value),
            .left_q   (left_q),
            .right_q  (right_q),
            .data_q   (cell_q[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_capacity_limit_ff <= bisa_pkg::CAP_RESET;
         count_ff              <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            csr_capacity_limit_ff <= csr_write_data;
         end
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff  <= rsp_read_value_in;
         rsp_status_ff      <= rsp_status_in;
         rsp_entry_count_ff <= count_in_ext[bisa_pkg::POS_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   `BISA_NEVER(a_count_bound, clock, reset, count_ext > DEPTH_C)
   `BISA_ASSERT(a_ins_grows, clock, reset, cell_ctrl.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
   `BISA_ASSERT(a_pop_shrinks, clock, reset, cell_ctrl.pop |=> count_ff == $past(count_ff) - CNT_W'(1))
   `BISA_ASSERT(a_stall_needs_rsp, clock, reset, req_stall |-> rsp_valid_ff)

endmodule

FILE: rtl/bisa_cell.sv
// One storage cell of the shift chain: holds one entry, shifts up or down, or loads the request value.
module bisa_cell #(
   parameter int INDEX = 0,
   parameter int CMP_W = bisa_pkg::POS_W
) (
   input  logic                          clock,
   input  bisa_pkg::cell_ctrl_type       ctrl,
   input  logic [CMP_W-1:0]              position,
   input  logic [bisa_pkg::DATA_W-1:0]   value,
   input  logic [bisa_pkg::DATA_W-1:0]   left_q,
   input  logic [bisa_pkg::DATA_W-1:0]   right_q,
   output logic [bisa_pkg::DATA_W-1:0]   data_q
);

   localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

   logic [bisa_pkg::DATA_W-1:0] data_ff;
   logic [bisa_pkg::DATA_W-1:0] data_in;
   logic                        above;
   logic                        hit;

   assign above = (MY_INDEX > position);
   assign hit   = (MY_INDEX == position);

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (above) begin
            data_in = left_q;
         end else if (hit) begin
            data_in = value;
         end
      end else if (ctrl.pop) begin
         data_in = right_q;
      end else if (ctrl.wr && hit) begin
         data_in = value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

FILE: tb/sv/bounded_insert_shift_array_unit_test.sv
// Testbench for the bounded insert/shift array: directed table, random requests, shadow store.
`timescale 1ns / 100ps

module bounded_insert_shift_array_unit_test;

   localparam int STORE_DEPTH = bisa_pkg::DEPTH_DEFAULT;
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   localparam int PHASE_ITEMS = 200;
   localparam int HOLD_CYCLES = 80;

   typedef struct {
      logic signed [bisa_pkg::DATA_W-1:0] read_value;
      bisa_pkg::status_type               status;
      logic [bisa_pkg::POS_W-1:0]         entry_count;
   } store_result_type;

   typedef struct {
      logic [2:0]                         mode;
      logic [bisa_pkg::POS_W-1:0]         position;
      logic signed [bisa_pkg::DATA_W-1:0] value;
      bit                                 has_literal;
      store_result_type                   literal;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [2:0]                         req_mode = bisa_pkg::MODE_INSERT;
   logic [bisa_pkg::POS_W-1:0]         req_position = '0;
   logic signed [bisa_pkg::DATA_W-1:0] req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [bisa_pkg::DATA_W-1:0] rsp_read_value;
   logic [1:0]                         rsp_status;
   logic [bisa_pkg::POS_W-1:0]         rsp_entry_count;
   logic                               csr_write_enable = 1'b0;
   logic [bisa_pkg::CAP_W-1:0]         csr_write_data = '0;

   // shadow copy of the store
   logic signed [bisa_pkg::DATA_W-1:0] shadow_words [STORE_DEPTH];
   int unsigned                        shadow_count = 0;
   logic [bisa_pkg::CAP_W-1:0]         shadow_capacity = bisa_pkg::CAP_RESET;

   store_result_type                   expected_results [$];
   stim_row_type                       directed_rows [$];
   store_result_type                   no_literal;
   int                                 mismatch_count = 0;
   int                                 send_idle_pct = 0;
   int                                 recv_stall_pct = 0;
   int                                 hold_asks = 0;

   bounded_insert_shift_array_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic store_result_type apply_store_op(
      logic [2:0] mode, logic [bisa_pkg::POS_W-1:0] pos,
      logic signed [bisa_pkg::DATA_W-1:0] val);
      store_result_type r;
      int unsigned      lim;
      int unsigned      i;
      r.read_value = '0;
      r.status     = bisa_pkg::ST_OK;
      lim = (shadow_capacity < STORE_DEPTH) ? shadow_capacity : STORE_DEPTH;
      case (mode)
         bisa_pkg::MODE_INSERT: begin
            if (shadow_count >= lim) begin
               r.status = bisa_pkg::ST_FULL;
            end else if (pos > shadow_count) begin
               r.status = bisa_pkg::ST_RANGE;
            end else begin
               for (i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[pos] = val;
               shadow_count++;
            end
         end
         bisa_pkg::MODE_POP_FRONT: begin
            if (shadow_count == 0) begin
               r.status = bisa_pkg::ST_EMPTY;
            end else begin
               for (i = 0; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
               shadow_count--;
            end
         end
         bisa_pkg::MODE_POP_BACK: begin
            if (shadow_count == 0) r.status = bisa_pkg::ST_EMPTY;
            else shadow_count--;
         end
         bisa_pkg::MODE_READ: begin
            if (pos >= shadow_count) r.status = bisa_pkg::ST_RANGE;
            else r.read_value = shadow_words[pos];
         end
         bisa_pkg::MODE_WRITE: begin
            if (pos >= shadow_count) r.status = bisa_pkg::ST_RANGE;
            else shadow_words[pos] = val;
         end
         default: begin
         end
      endcase
      r.entry_count = bisa_pkg::POS_W'(shadow_count);
      return r;
   endfunction

   function automatic void add_row(logic [2:0] mode, logic [bisa_pkg::POS_W-1:0] pos,
                                   logic signed [bisa_pkg::DATA_W-1:0] val, bit lit,
                                   logic signed [bisa_pkg::DATA_W-1:0] rv,
                                   bisa_pkg::status_type st,
                                   logic [bisa_pkg::POS_W-1:0] cnt);
      stim_row_type row;
      row.mode     = mode;
      row.position = pos;
      row.value    = val;
      row.has_literal = lit;
      row.literal.read_value  = rv;
      row.literal.status      = st;
      row.literal.entry_count = cnt;
      directed_rows.push_back(row);
   endfunction

   task automatic issue_request(logic [2:0] mode, logic [bisa_pkg::POS_W-1:0] pos,
                                logic signed [bisa_pkg::DATA_W-1:0] val, bit lit,
                                store_result_type fixed);
      store_result_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      predicted = apply_store_op(mode, pos, val);
      expected_results.push_back(lit ? fixed : predicted);
   endtask

   task automatic issue_random_request(bit filling);
      logic [2:0]                         mode;
      logic [bisa_pkg::POS_W-1:0]         pos;
      logic signed [bisa_pkg::DATA_W-1:0] val;
      int                                 r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      end else if (r < (filling ? 64 : 24)) begin
         mode = bisa_pkg::MODE_INSERT;
      end else begin
         case ($urandom_range(0, 3))
            0: mode = bisa_pkg::MODE_POP_FRONT;
            1: mode = bisa_pkg::MODE_POP_BACK;
            2: mode = bisa_pkg::MODE_READ;
            default: mode = bisa_pkg::MODE_WRITE;
         endcase
      end
      if ($urandom_range(0, 9) == 0) pos = bisa_pkg::POS_W'($urandom_range(0, 63));
      else if (mode == bisa_pkg::MODE_INSERT)
         pos = bisa_pkg::POS_W'($urandom_range(0, shadow_count));
      else if (shadow_count == 0) pos = '0;
      else pos = bisa_pkg::POS_W'($urandom_range(0, shadow_count - 1));
      case ($urandom_range(0, 15))
         0: val = 32'sh7FFF_FFFF;
         1: val = 32'sh8000_0000;
         2: val = '0;
         3: val = -32'sd1;
         default: val = $urandom;
      endcase
      issue_request(mode, pos, val, 1'b0, no_literal);
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [bisa_pkg::CAP_W-1:0] cap);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity = cap;
   endtask

   // response side: random stall plus an occasional long hold
   int hold_seen = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      store_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_entry_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [bisa_pkg::CAP_W-1:0] phase_caps [8];
      int p;
      int n;
      phase_caps = '{6'd20, 6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd31, 6'd33};
      for (int i = 0; i < STORE_DEPTH; i++) shadow_words[i] = '0;
      no_literal = '{read_value: '0, status: bisa_pkg::ST_OK, entry_count: '0};

      // empty store after reset, capacity 20
      add_row(bisa_pkg::MODE_POP_FRONT, 6'd0, 32'sd0, 1, 32'sd0, bisa_pkg::ST_EMPTY, 6'd0);
      add_row(bisa_pkg::MODE_POP_BACK, 6'd0, 32'sd0, 1, 32'sd0, bisa_pkg::ST_EMPTY, 6'd0);
      add_row(bisa_pkg::MODE_READ, 6'd0, 32'sd0, 1, 32'sd0, bisa_pkg::ST_RANGE, 6'd0);
      add_row(bisa_pkg::MODE_WRITE, 6'd0, 32'sd5, 1, 32'sd0, bisa_pkg::ST_RANGE, 6'd0);
      add_row(bisa_pkg::MODE_INSERT, 6'd1, 32'sd9, 1, 32'sd0, bisa_pkg::ST_RANGE, 6'd0);
      add_row(bisa_pkg::MODE_INSERT, 6'd0, 32'sh7FFF_FFFF, 1, 32'sd0, bisa_pkg::ST_OK, 6'd1);
      add_row(bisa_pkg::MODE_INSERT, 6'd0, 32'sh8000_0000, 1, 32'sd0, bisa_pkg::ST_OK, 6'd2);
      add_row(bisa_pkg::MODE_INSERT, 6'd2, -32'sd1, 1, 32'sd0, bisa_pkg::ST_OK, 6'd3);
      add_row(bisa_pkg::MODE_INSERT, 6'd1, 32'sh5555_5555, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(bisa_pkg::MODE_READ, 6'd0, 32'sd0, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(bisa_pkg::MODE_READ, 6'd63, 32'sd0, 1, 32'sd0, bisa_pkg::ST_RANGE, 6'd4);
      add_row(bisa_pkg::MODE_WRITE, 6'd3, 32'shAAAA_AAAA, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(bisa_pkg::MODE_WRITE, 6'd4, 32'sd1, 1, 32'sd0, bisa_pkg::ST_RANGE, 6'd4);
      add_row(bisa_pkg::MODE_READ, 6'd3, 32'sd0, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(MODE_UNUSED_LO, 6'd0, 32'sd7, 1, 32'sd0, bisa_pkg::ST_OK, 6'd4);
      add_row(MODE_UNUSED_HI, 6'd63, -32'sd1, 1, 32'sd0, bisa_pkg::ST_OK, 6'd4);
      add_row(bisa_pkg::MODE_POP_FRONT, 6'd0, 32'sd0, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(bisa_pkg::MODE_READ, 6'd0, 32'sd0, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(bisa_pkg::MODE_POP_BACK, 6'd0, 32'sd0, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(bisa_pkg::MODE_READ, 6'd1, 32'sd0, 0, 32'sd0, bisa_pkg::ST_OK, 6'd0);
      add_row(bisa_pkg::MODE_INSERT, 6'd63, 32'sd3, 1, 32'sd0, bisa_pkg::ST_RANGE, 6'd2);
      add_row(bisa_pkg::MODE_READ, 6'd32, 32'sd0, 1, 32'sd0, bisa_pkg::ST_RANGE, 6'd2);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct  = 20;
      recv_stall_pct = 53;
      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].mode, directed_rows[i].position,
                       directed_rows[i].value, directed_rows[i].has_literal,
                       directed_rows[i].literal);
      end

      for (p = 0; p < 8; p++) begin
         if (p < 3) begin
            send_idle_pct  = 20;
            recv_stall_pct = 53;
         end else if (p < 6) begin
            send_idle_pct  = 53;
            recv_stall_pct = 20;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         drain_requests();
         write_capacity(phase_caps[p]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 50 && (p == 1 || p == 4 || p == 7)) hold_asks++;
            if (n == 120) drain_requests();
            issue_random_request(((n / 40) % 2) == 0);
         end
      end

      drain_requests();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
